FILE: hdl/tlw_pkg.sv
// Shared types and constants for the terminal line wrapper.
`default_nettype none

package tlw_pkg;

	localparam int COUNT_BITS = 16;
	localparam int OUT_BITS = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int SLOTS = 6;
	localparam int LINE_SLOTS = 3;

	localparam logic REG_SCREEN_COLUMNS = 1'b0;
	localparam logic REG_ATTACHMENT_MODE = 1'b1;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [2:0] {
		KIND_NORMAL      = 3'd0,
		KIND_NORMAL_OPEN = 3'd1,
		KIND_QUOTE       = 3'd2,
		KIND_QUOTE_OPEN  = 3'd3,
		KIND_ATTACH_INFO = 3'd4,
		KIND_ATTACH_LINK = 3'd5,
		KIND_ALL_LINKS   = 3'd6
	} line_kind_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] bytes_used;
		logic [OUT_BITS-1:0] display_length;
		line_kind_t          kind;
	} line_t;

	// Results of one input byte: three line slots then three pseudo-line slots.
	typedef struct packed {
		line_t [LINE_SLOTS-1:0] line;
		logic [SLOTS-1:0]       mask;
	} batch_t;

endpackage

`default_nettype wire

FILE: hdl/tlw_front.sv
// Front end: accepts bytes, tracks the open line and builds the result batch of each byte.
`default_nettype none

module tlw_front import tlw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_buffer,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       full,
	output logic            push,
	output batch_t          batch
);

	localparam logic [1:0] QP_UNKNOWN = 2'd0;
	localparam logic [1:0] QP_COLON = 2'd1;
	localparam logic [1:0] QP_QUOTE = 2'd2;
	localparam logic [1:0] QP_NONE = 2'd3;
	localparam count_t COUNT_MAX = '1;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_ESC = 8'h1B;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef logic [COUNT_BITS:0] wide_t;

	typedef struct packed {
		count_t      column_width;
		count_t      byte_count;
		logic        in_escape;
		logic        second_half;
		logic [1:0]  quote_prefix;
		line_kind_t  previous_kind;
	} line_state_t;

	typedef struct packed {
		line_state_t st;
		logic        line_valid;
		line_t       line;
	} feed_res_t;

	function automatic logic [OUT_BITS-1:0] to_out(count_t v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[OUT_BITS-1:0];
	endfunction

	function automatic line_t end_line(line_state_t s, logic term);
		line_kind_t k;
		count_t b;
		line_t l;
		if (s.previous_kind == KIND_NORMAL_OPEN)
			k = term ? KIND_NORMAL : KIND_NORMAL_OPEN;
		else if (s.previous_kind == KIND_QUOTE_OPEN)
			k = term ? KIND_QUOTE : KIND_QUOTE_OPEN;
		else if (s.quote_prefix == QP_QUOTE)
			k = term ? KIND_QUOTE : KIND_QUOTE_OPEN;
		else
			k = term ? KIND_NORMAL : KIND_NORMAL_OPEN;
		b = s.byte_count;
		if (term && b != COUNT_MAX)
			b = b + 1'b1;
		l.bytes_used = to_out(b);
		l.display_length = to_out(s.byte_count);
		l.kind = k;
		return l;
	endfunction

	function automatic line_state_t cleared(line_state_t s, line_kind_t k);
		line_state_t r;
		r = s;
		r.column_width = '0;
		r.byte_count = '0;
		r.in_escape = 1'b0;
		r.second_half = 1'b0;
		r.quote_prefix = QP_UNKNOWN;
		r.previous_kind = k;
		return r;
	endfunction

	function automatic feed_res_t feed(line_state_t st, logic [7:0] b, logic last,
			logic [7:0] nxt, logic [7:0] cols);
		feed_res_t r;
		line_state_t s;
		wide_t w;
		logic printable;
		logic letter;
		s = st;
		r.line_valid = 1'b0;
		r.line = end_line(st, 1'b1);
		printable = (b >= 8'h80) || (b >= 8'h20 && b <= 8'h7E);
		letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
		w = ({1'b0, s.column_width} + wide_t'(8)) & ~wide_t'(7);
		if (b == CHAR_LF) begin
			r.line_valid = 1'b1;
			s = cleared(s, r.line.kind);
		end else begin
			if (b == CHAR_TAB) begin
				s.second_half = 1'b0;
				s.column_width = w[COUNT_BITS] ? COUNT_MAX : w[COUNT_BITS-1:0];
			end else if (b == CHAR_ESC) begin
				s.second_half = 1'b0;
				s.in_escape = 1'b1;
			end else if (s.in_escape) begin
				if (letter)
					s.in_escape = 1'b0;
			end else if (printable) begin
				if (!s.second_half) begin
					if (s.byte_count != '0 &&
							(({1'b0, s.column_width} + 1'b1 >= wide_t'(cols) &&
							(last || nxt[7])) ||
							{1'b0, s.column_width} >= wide_t'(cols))) begin
						r.line = end_line(s, 1'b0);
						r.line_valid = 1'b1;
						s = cleared(s, r.line.kind);
					end
					if (b[7])
						s.second_half = 1'b1;
				end else begin
					s.second_half = 1'b0;
				end
				if (s.column_width != COUNT_MAX)
					s.column_width = s.column_width + 1'b1;
			end
			if (s.byte_count == '0)
				s.quote_prefix = (b == CHAR_COLON) ? QP_COLON : QP_NONE;
			else if (s.byte_count == count_t'(1))
				s.quote_prefix = (s.quote_prefix == QP_COLON && b == CHAR_SPACE) ?
					QP_QUOTE : QP_NONE;
			if (s.byte_count != COUNT_MAX)
				s.byte_count = s.byte_count + 1'b1;
		end
		r.st = s;
		return r;
	endfunction

	logic [7:0]  cols_q;
	logic        attach_q;
	logic [7:0]  held_q;
	logic        held_valid_q;
	line_state_t state_q;
	line_state_t state_d;
	feed_res_t   r1;
	feed_res_t   r2;
	line_t       l3;
	logic        v1;
	logic        v2;
	logic        v3;
	logic        accept;
	logic [SLOTS-1:0] mask;

	assign in_ready = !full;
	assign accept = in_valid && !full;

	always_comb begin
		r1 = feed(state_q, held_q, 1'b0, text_byte, cols_q);
		v1 = held_valid_q && r1.line_valid;
		state_d = held_valid_q ? r1.st : state_q;
		r2 = feed(state_d, text_byte, 1'b1, 8'h00, cols_q);
		v2 = end_of_buffer && r2.line_valid;
		l3 = end_line(r2.st, 1'b0);
		v3 = end_of_buffer && (r2.st.byte_count != '0);
		mask = {attach_q && end_of_buffer, attach_q && end_of_buffer,
			attach_q && end_of_buffer, v3, v2, v1};
		if (&mask)
			mask[SLOTS-1] = 1'b0;
		batch.line[0] = r1.line;
		batch.line[1] = r2.line;
		batch.line[2] = l3;
		batch.mask = mask;
		push = accept && (|mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 8'd80;
			attach_q <= 1'b0;
			held_q <= '0;
			held_valid_q <= 1'b0;
			state_q <= cleared('0, KIND_NORMAL);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SCREEN_COLUMNS:  cols_q <= cfg_data;
					REG_ATTACHMENT_MODE: attach_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				if (end_of_buffer) begin
					held_q <= '0;
					held_valid_q <= 1'b0;
					state_q <= cleared(r2.st, KIND_NORMAL);
				end else begin
					held_q <= text_byte;
					held_valid_q <= 1'b1;
					state_q <= state_d;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/tlw_fifo.sv
// Short queue of result batches between the front and back ends.
`default_nettype none

module tlw_fifo import tlw_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire batch_t push_data,
	input  wire logic   pop,
	output batch_t      pop_data,
	output logic        full,
	output logic        empty
);

	batch_t                   mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_PTR_BITS:0]   count_q;

	assign full = (count_q == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/tlw_back.sv
// Back end: walks the slots of each batch and sends one result beat per cycle while out_ready is high.
`default_nettype none

module tlw_back import tlw_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         empty,
	input  wire batch_t       pop_data,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [OUT_BITS-1:0] bytes_used,
	output logic [OUT_BITS-1:0] display_length,
	output line_kind_t        line_kind,
	output logic              last_of_run
);

	batch_t           batch_q;
	logic [SLOTS-1:0] mask_q;
	logic [SLOTS-1:0] rest;
	logic [SLOTS-1:0] next_mask;
	logic [2:0]       slot;
	logic             take;

	always_comb begin
		slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i])
				slot = 3'(i);
		end
		rest = mask_q & (mask_q - 1'b1);
		out_valid = |mask_q;
		last_of_run = (rest == '0);
		take = out_valid && out_ready;
		next_mask = take ? rest : mask_q;
		pop = (next_mask == '0) && !empty;
		bytes_used = '0;
		display_length = '0;
		case (slot)
			3'd0, 3'd1, 3'd2: begin
				bytes_used = batch_q.line[slot[1:0]].bytes_used;
				display_length = batch_q.line[slot[1:0]].display_length;
				line_kind = batch_q.line[slot[1:0]].kind;
			end
			3'd3: line_kind = KIND_ATTACH_INFO;
			3'd4: line_kind = KIND_ATTACH_LINK;
			default: line_kind = KIND_ALL_LINKS;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop)
			batch_q <= pop_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else begin
			mask_q <= pop ? pop_data.mask : next_mask;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/terminal_line_wrapper.sv
// Top level of the terminal line wrapper: front end, batch queue and back end.
// One byte is accepted per cycle while the four-entry batch queue has room.
// Each byte yields zero to five result beats, sent at one beat per cycle while m_axis_tready is high.
// A byte's beats pass through the batch queue and then the back end's batch register; a line
// that ends at a byte is reported with the following byte, which it needs.
// Reset clears line state, queue and output; screen_columns returns to 80.
`default_nettype none

module terminal_line_wrapper import tlw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] text_byte
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [15:0] bytes_used, [31:16] display_length
	output logic [2:0]       m_axis_tuser,  // [2:0] line_kind
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	batch_t               push_data;
	batch_t               pop_data;
	logic                 push;
	logic                 pop;
	logic                 full;
	logic                 empty;
	logic [OUT_BITS-1:0]  bytes_used;
	logic [OUT_BITS-1:0]  display_length;
	line_kind_t           line_kind;

	tlw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.text_byte     (s_axis_tdata),
		.end_of_buffer (s_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.full          (full),
		.push          (push),
		.batch         (push_data)
	);

	tlw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	tlw_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (empty),
		.pop_data       (pop_data),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.bytes_used     (bytes_used),
		.display_length (display_length),
		.line_kind      (line_kind),
		.last_of_run    (m_axis_tlast)
	);

	assign m_axis_tdata = {display_length, bytes_used};
	assign m_axis_tuser = line_kind;

endmodule

`default_nettype wire

FILE: hdl/tlw_checker.sv
// Port-level checks for the terminal line wrapper and their binding.
`default_nettype none

module tlw_checker import tlw_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [2:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	// A stalled beat keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// Pseudo-lines carry no counts.
	a_pseudo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_ATTACH_INFO ||
		m_axis_tuser == KIND_ATTACH_LINK || m_axis_tuser == KIND_ALL_LINKS) |->
		m_axis_tdata == 32'd0)
		else $error("pseudo-line with non-zero counts");

	// The attachment information line is always followed by a link line.
	a_info_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_ATTACH_INFO |-> !m_axis_tlast)
		else $error("attachment information line ends a run");

	// A terminated line counts its newline.
	a_term_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_NORMAL || m_axis_tuser == KIND_QUOTE) |->
		m_axis_tdata[15:0] != 16'd0)
		else $error("terminated line with no bytes");

	// Line kinds above all-links never appear.
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= KIND_ALL_LINKS)
		else $error("undefined line kind");

endmodule

bind terminal_line_wrapper tlw_checker u_tlw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: dv/terminal_line_wrapper_tb.sv
// Self-checking testbench for the terminal line wrapper: a directed table and random text buffers.
`timescale 1ns / 100ps

module terminal_line_wrapper_tb;
	import tlw_pkg::*;

	localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned MAX_REPORTS = 40;
	localparam int unsigned IDLE_PCT = 24;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef enum logic [1:0] {PFX_UNKNOWN, PFX_COLON, PFX_QUOTE, PFX_NONE} prefix_e;
	typedef enum logic {ROW_BYTE, ROW_SETUP} row_op_e;

	typedef struct packed {
		logic [OUT_BITS-1:0] bytes_used;
		logic [OUT_BITS-1:0] display_length;
		line_kind_t          kind;
		logic                last;
	} line_beat_t;

	typedef struct packed {
		row_op_e             op;
		logic [7:0]          value;
		logic                flag;
		logic                pinned;
		logic [OUT_BITS-1:0] want_bytes;
		logic [OUT_BITS-1:0] want_shown;
		line_kind_t          want_kind;
	} script_row_t;

	// A byte row uses flag as end of buffer; a setup row uses it as the register index.
	localparam script_row_t SCRIPT [27] = '{
		'{ROW_BYTE, CH_COLON, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, CH_SPACE, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, "a", 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, CH_NEWLINE, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, "b", 1'b0, 1'b1, 16'd4, 16'd3, KIND_QUOTE},
		'{ROW_BYTE, CH_TAB, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, CH_ESC, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, "[", 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, "m", 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, 8'h80, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, 8'hE3, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, 8'h00, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, 8'h7F, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, CH_NEWLINE, 1'b1, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_SETUP, 8'd2, REG_SCREEN_COLUMNS, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_SETUP, 8'd1, REG_ATTACHMENT_MODE, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, "a", 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, "b", 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, "c", 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, "d", 1'b1, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, "x", 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, "y", 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, 8'hC0, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, 8'hC1, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, CH_ESC, 1'b0, 1'b0, 16'd0, 16'd0, KIND_NORMAL},
		'{ROW_BYTE, CH_NEWLINE, 1'b1, 1'b0, 16'd0, 16'd0, KIND_NORMAL}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	int unsigned screen_cols = 80;
	bit          attach_on = 1'b0;
	logic [7:0]  lookahead_byte = 8'h00;
	bit          lookahead_full = 1'b0;
	int unsigned cols_used = 0;
	int unsigned line_bytes = 0;
	bit          esc_open = 1'b0;
	bit          want_second = 1'b0;
	prefix_e     prefix_state = PFX_UNKNOWN;
	line_kind_t  prior_kind = KIND_NORMAL;

	line_beat_t  step_lines[$];
	line_beat_t  lines_due[$];

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned feed_idle_pct = IDLE_PCT;
	int unsigned drain_idle_pct = IDLE_PCT;
	bit          hold_request = 1'b0;
	int unsigned hold_left = 0;

	terminal_line_wrapper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void emit_line(int unsigned nbytes, int unsigned shown, line_kind_t k);
		if (step_lines.size() < 5)
			step_lines.push_back(line_beat_t'{OUT_BITS'(nbytes), OUT_BITS'(shown), k, 1'b0});
	endfunction

	function automatic void reset_line();
		cols_used = 0;
		line_bytes = 0;
		esc_open = 1'b0;
		want_second = 1'b0;
		prefix_state = PFX_UNKNOWN;
	endfunction

	function automatic void close_line(bit terminated);
		line_kind_t  k;
		int unsigned n;
		n = line_bytes;
		if (prior_kind == KIND_NORMAL_OPEN)
			k = terminated ? KIND_NORMAL : KIND_NORMAL_OPEN;
		else if (prior_kind == KIND_QUOTE_OPEN || prefix_state == PFX_QUOTE)
			k = terminated ? KIND_QUOTE : KIND_QUOTE_OPEN;
		else
			k = terminated ? KIND_NORMAL : KIND_NORMAL_OPEN;
		if (terminated && n < COUNT_MAX)
			n++;
		emit_line(n, line_bytes, k);
		prior_kind = k;
		reset_line();
	endfunction

	function automatic void count_byte(logic [7:0] b);
		if (line_bytes == 0)
			prefix_state = (b == CH_COLON) ? PFX_COLON : PFX_NONE;
		else if (line_bytes == 1)
			prefix_state = (prefix_state == PFX_COLON && b == CH_SPACE) ? PFX_QUOTE : PFX_NONE;
		if (line_bytes < COUNT_MAX)
			line_bytes++;
	endfunction

	function automatic void place_byte(logic [7:0] b, bit is_last, logic [7:0] nxt);
		int unsigned w;
		if (b == CH_NEWLINE) begin
			close_line(1'b1);
			return;
		end
		if (b == CH_TAB) begin
			want_second = 1'b0;
			w = (cols_used + 8) & ~32'd7;
			cols_used = (w > COUNT_MAX) ? COUNT_MAX : w;
		end else if (b == CH_ESC) begin
			want_second = 1'b0;
			esc_open = 1'b1;
		end else if (esc_open) begin
			if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))
				esc_open = 1'b0;
		end else if (b[7] || (b >= 8'h20 && b <= 8'h7E)) begin
			if (!want_second) begin
				if (line_bytes != 0 && ((cols_used + 1 >= screen_cols && (is_last || nxt[7]))
						|| cols_used >= screen_cols))
					close_line(1'b0);
				if (b[7])
					want_second = 1'b1;
			end else begin
				want_second = 1'b0;
			end
			if (cols_used < COUNT_MAX)
				cols_used++;
		end
		count_byte(b);
	endfunction

	// The lines that one accepted byte completes, with end of run marked on the last.
	function automatic void wrap_step(logic [7:0] b, bit eob);
		step_lines.delete();
		if (lookahead_full)
			place_byte(lookahead_byte, 1'b0, b);
		lookahead_byte = b;
		lookahead_full = 1'b1;
		if (eob) begin
			place_byte(b, 1'b1, 8'h00);
			lookahead_full = 1'b0;
			lookahead_byte = 8'h00;
			if (line_bytes != 0)
				close_line(1'b0);
			if (attach_on) begin
				emit_line(0, 0, KIND_ATTACH_INFO);
				emit_line(0, 0, KIND_ATTACH_LINK);
				emit_line(0, 0, KIND_ALL_LINKS);
			end
			prior_kind = KIND_NORMAL;
			reset_line();
		end
		if (step_lines.size() > 0)
			step_lines[step_lines.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic offer_byte(input logic [7:0] b, input logic eob);
		while ($urandom_range(0, 99) < feed_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eob;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic queue_step_lines();
		foreach (step_lines[j])
			lines_due.push_back(step_lines[j]);
	endtask

	task automatic send_item(input logic [7:0] b, input logic eob);
		offer_byte(b, eob);
		wrap_step(b, eob);
		queue_step_lines();
	endtask

	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		while (lines_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SCREEN_COLUMNS)
			screen_cols = val;
		else
			attach_on = val[0];
	endtask

	task automatic set_mode(input logic [7:0] cols, input logic attach);
		write_reg(REG_SCREEN_COLUMNS, cols);
		write_reg(REG_ATTACHMENT_MODE, {7'd0, attach});
	endtask

	// Random text with newlines, tabs, escapes, two-byte characters and quote prefixes.
	task automatic send_text(input int unsigned count);
		int unsigned k;
		int unsigned r;
		logic [7:0]  b;
		bit          eob;
		bit          fresh;
		k = 0;
		fresh = 1'b1;
		while (k < count) begin
			if (fresh && $urandom_range(0, 2) == 0 && k + 2 < count) begin
				send_item(CH_COLON, 1'b0);
				send_item(CH_SPACE, 1'b0);
				k += 2;
			end
			r = $urandom_range(0, 99);
			if (r < 12)
				b = CH_NEWLINE;
			else if (r < 17)
				b = CH_TAB;
			else if (r < 21)
				b = CH_ESC;
			else if (r < 33)
				b = 8'h80 | 8'($urandom);
			else if (r < 39)
				b = 8'($urandom_range(0, 31));
			else if (r < 45)
				b = CH_COLON;
			else if (r < 48)
				b = CH_SPACE;
			else if (r < 60)
				b = 8'($urandom);
			else
				b = 8'($urandom_range(32, 126));
			k++;
			eob = (k == count) || ($urandom_range(0, 24) == 0);
			send_item(b, eob);
			fresh = (b == CH_NEWLINE) || eob;
		end
	endtask

	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= drain_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_beat
		line_beat_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (lines_due.size() == 0) begin
				report_mismatch("result beat with no line outstanding");
			end else begin
				due = lines_due.pop_front();
				if (m_axis_tdata[15:0] !== due.bytes_used)
					report_mismatch($sformatf("bytes_used %0d, expected %0d",
						m_axis_tdata[15:0], due.bytes_used));
				if (m_axis_tdata[31:16] !== due.display_length)
					report_mismatch($sformatf("display_length %0d, expected %0d",
						m_axis_tdata[31:16], due.display_length));
				if (m_axis_tuser !== due.kind)
					report_mismatch($sformatf("line_kind %0d, expected %0d",
						m_axis_tuser, due.kind));
				if (m_axis_tlast !== due.last)
					report_mismatch($sformatf("last_of_run %0b, expected %0b",
						m_axis_tlast, due.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL terminal_line_wrapper");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		s_axis_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SCREEN_COLUMNS;
		cfg_data <= 8'h00;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].op == ROW_SETUP) begin
				write_reg(SCRIPT[i].flag, SCRIPT[i].value);
			end else begin
				offer_byte(SCRIPT[i].value, SCRIPT[i].flag);
				wrap_step(SCRIPT[i].value, SCRIPT[i].flag);
				if (SCRIPT[i].pinned)
					lines_due.push_back('{SCRIPT[i].want_bytes, SCRIPT[i].want_shown,
						SCRIPT[i].want_kind, 1'b1});
				else
					queue_step_lines();
			end
		end

		// An unterminated line on the widest screen.
		set_mode(8'd255, 1'b0);
		offer_byte(CH_COLON, 1'b0);
		wrap_step(CH_COLON, 1'b0);
		queue_step_lines();
		offer_byte(CH_COLON, 1'b1);
		wrap_step(CH_COLON, 1'b1);
		lines_due.push_back('{16'd2, 16'd2, KIND_NORMAL_OPEN, 1'b1});

		// A long stretch of text with no idling on either side.
		feed_idle_pct = 0;
		drain_idle_pct = 0;
		set_mode(8'd80, 1'b0);
		send_text(80);
		feed_idle_pct = IDLE_PCT;
		drain_idle_pct = IDLE_PCT;

		set_mode(8'd2, 1'b1);
		hold_request = 1'b1;
		send_text(80);
		set_mode(8'd255, 1'b1);
		send_text(80);
		repeat (3) begin
			n = $urandom_range(0, 1) ? $urandom_range(2, 12) : $urandom_range(2, 255);
			set_mode(8'(n), 1'($urandom_range(0, 1)));
			send_text(65);
		end

		wait_quiet();
		if (mismatches == 0)
			$display("PASS terminal_line_wrapper");
		else
			$display("FAIL terminal_line_wrapper");
		$finish;
	end

endmodule

FILE: sim.f
hdl/tlw_pkg.sv
hdl/tlw_front.sv
hdl/tlw_fifo.sv
hdl/tlw_back.sv
hdl/terminal_line_wrapper.sv
hdl/tlw_checker.sv
dv/terminal_line_wrapper_tb.sv
